// ----- hdl/scp_pkg.sv -----
// shared definitions for the second chance page replacer
// frame count, derived widths, sequencer states and outcome codes; no dependencies
package scp_pkg;

    // number of page frames in the queue
    localparam int FRAMES = 8;
    localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W  = $clog2(FRAMES + 1);

    // field widths
    localparam int PID_W   = 8;
    localparam int PAGE_W  = 8;
    localparam int KEY_W   = PID_W + PAGE_W;
    localparam int ENTRY_W = KEY_W + 1;
    localparam int OUTC_W  = 2;
    localparam int FIDX_W  = 3;
    localparam int CHNC_W  = 4;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 32;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ROTATE
    } t_state;

    // result outcome codes
    typedef enum logic [OUTC_W-1:0] {
        OUTC_HIT   = 2'd0,
        OUTC_FREE  = 2'd1,
        OUTC_EVICT = 2'd2
    } t_outcome;

endpackage

// ----- hdl/second_chance_page_replacer.sv -----
// second chance page replacer: serial lookup over the frame queue, then fill or rotate
// depends on scp_pkg
// one item at a time, set by the single shared key comparator that scans one frame
// per cycle and the queue head that rotates one entry per cycle; the next item is
// accepted in the cycle after the result is registered. reset (sync, active low)
// marks all frames free.
module second_chance_page_replacer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // process_id[7:0], page_number[15:8], ref_bit[16], zero[23:17]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // outcome[1:0], frame_index[4:2], evicted_process[12:5],
                                     // evicted_page[20:13], second_chances[24:21], zero[31:25]
);

    scp_pkg::t_state r_state, n_state;

    // frame queue: valid bits and entries (key in upper bits, reference bit in bit 0)
    logic [scp_pkg::FRAMES-1:0]  r_occ, n_occ;
    logic [scp_pkg::ENTRY_W-1:0] r_entry [scp_pkg::FRAMES];
    logic [scp_pkg::ENTRY_W-1:0] n_entry [scp_pkg::FRAMES];

    // current request
    logic [scp_pkg::KEY_W-1:0] r_key, n_key;
    logic                      r_bit, n_bit;

    // scan and rotate bookkeeping
    logic [scp_pkg::IDX_W-1:0] r_idx, n_idx;
    logic                      r_free_found, n_free_found;
    logic [scp_pkg::IDX_W-1:0] r_free_idx, n_free_idx;
    logic [scp_pkg::CNT_W-1:0] r_cnt, n_cnt;

    // result register
    logic                      r_out_valid, n_out_valid;
    logic [scp_pkg::OUT_W-1:0] r_out_data, n_out_data;

    logic [scp_pkg::ENTRY_W-1:0] w_cur;
    logic [scp_pkg::ENTRY_W-1:0] w_head;
    logic                        w_match;
    logic                        w_last;
    logic                        w_out_free;
    logic                        w_ffound;
    logic [scp_pkg::IDX_W-1:0]   w_fidx;

    assign o_s_tready = (r_state == scp_pkg::S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // shared compare unit on the frame under the scan index
    assign w_cur      = r_entry[r_idx];
    assign w_head     = r_entry[0];
    assign w_match    = r_occ[r_idx] && (w_cur[scp_pkg::ENTRY_W-1:1] == r_key);
    assign w_last     = (r_idx == scp_pkg::IDX_W'(scp_pkg::FRAMES - 1));
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_ffound   = r_free_found || !r_occ[r_idx];
    assign w_fidx     = r_free_found ? r_free_idx : r_idx;

    // pack one result word
    function automatic logic [scp_pkg::OUT_W-1:0] pack_result(
        input scp_pkg::t_outcome           outc,
        input logic [scp_pkg::IDX_W-1:0]   fidx,
        input logic [scp_pkg::PID_W-1:0]   ev_pid,
        input logic [scp_pkg::PAGE_W-1:0]  ev_page,
        input logic [scp_pkg::CNT_W-1:0]   chances
    );
        logic [scp_pkg::IDX_W+scp_pkg::FIDX_W-1:0] fwide;
        logic [scp_pkg::CNT_W+scp_pkg::CHNC_W-1:0] cwide;
        fwide = {{scp_pkg::FIDX_W{1'b0}}, fidx};
        cwide = {{scp_pkg::CHNC_W{1'b0}}, chances};
        pack_result = {7'd0, cwide[scp_pkg::CHNC_W-1:0], ev_page, ev_pid,
                       fwide[scp_pkg::FIDX_W-1:0], outc};
    endfunction

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_entry      <= n_entry;
        r_key        <= n_key;
        r_bit        <= n_bit;
        r_idx        <= n_idx;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_cnt        <= n_cnt;
        r_out_data   <= n_out_data;
    end

    // sequencer: next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_occ        = r_occ;
        n_entry      = r_entry;
        n_key        = r_key;
        n_bit        = r_bit;
        n_idx        = r_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;

        // result transaction drains the output register
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            scp_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_key        = i_s_tdata[scp_pkg::KEY_W-1:0];
                    n_bit        = i_s_tdata[scp_pkg::KEY_W];
                    n_idx        = '0;
                    n_free_found = 1'b0;
                    n_cnt        = '0;
                    n_state      = scp_pkg::S_SCAN;
                end
            end
            scp_pkg::S_SCAN: begin
                if (w_match) begin
                    // hit: nothing changes in the queue
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_out_data  = pack_result(scp_pkg::OUTC_HIT, r_idx, '0, '0, '0);
                        n_state     = scp_pkg::S_IDLE;
                    end
                end else if (!w_last) begin
                    n_free_found = w_ffound;
                    n_free_idx   = w_fidx;
                    n_idx        = r_idx + scp_pkg::IDX_W'(1);
                end else if (w_ffound) begin
                    // miss with a free frame: fill the lowest one
                    if (w_out_free) begin
                        n_occ[w_fidx]   = 1'b1;
                        n_entry[w_fidx] = {r_key, r_bit};
                        n_out_valid     = 1'b1;
                        n_out_data      = pack_result(scp_pkg::OUTC_FREE, w_fidx, '0, '0, '0);
                        n_state         = scp_pkg::S_IDLE;
                    end
                end else begin
                    n_state = scp_pkg::S_ROTATE;
                end
            end
            scp_pkg::S_ROTATE: begin
                if (w_head[0]) begin
                    // second chance: clear the bit and move the head to the tail
                    for (int i = 0; i < scp_pkg::FRAMES - 1; i++) begin
                        n_entry[i] = r_entry[i+1];
                    end
                    n_entry[scp_pkg::FRAMES-1] = {w_head[scp_pkg::ENTRY_W-1:1], 1'b0};
                    n_cnt = r_cnt + scp_pkg::CNT_W'(1);
                end else if (w_out_free) begin
                    // evict the head and append the new page at the tail
                    // entry holds page_number above process_id
                    for (int i = 0; i < scp_pkg::FRAMES - 1; i++) begin
                        n_entry[i] = r_entry[i+1];
                    end
                    n_entry[scp_pkg::FRAMES-1] = {r_key, r_bit};
                    n_out_valid = 1'b1;
                    n_out_data  = pack_result(scp_pkg::OUTC_EVICT,
                                              scp_pkg::IDX_W'(scp_pkg::FRAMES - 1),
                                              w_head[scp_pkg::PID_W:1],
                                              w_head[scp_pkg::ENTRY_W-1:scp_pkg::PID_W+1],
                                              r_cnt);
                    n_state     = scp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = scp_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/scp_checker.sv -----
// port-level checks for the second chance page replacer
// depends on scp_pkg; bound to second_chance_page_replacer below
module scp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [23:0] i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata
);

    // one item at a time: no second input transaction right after one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while an item is in work");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

    // only the three defined outcomes appear
    a_outcome_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[1:0] == scp_pkg::OUTC_HIT ||
                        o_m_tdata[1:0] == scp_pkg::OUTC_FREE ||
                        o_m_tdata[1:0] == scp_pkg::OUTC_EVICT))
        else $error("undefined outcome code");

    // eviction fields and second chances stay zero without an eviction
    a_no_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[1:0] != scp_pkg::OUTC_EVICT) |-> (o_m_tdata[24:5] == '0))
        else $error("eviction fields set without an eviction");

    // an evicted-for page always lands at the tail frame
    a_evict_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[1:0] == scp_pkg::OUTC_EVICT)
            |-> (o_m_tdata[4:2] == 3'(scp_pkg::FRAMES - 1)))
        else $error("eviction result not at the tail frame");

endmodule

bind second_chance_page_replacer scp_checker u_scp_checker (.*);

// ----- tb/sv/page_replacer_checker.sv -----
// checker for the second chance page replacer: watches both stream channels,
// predicts each lookup result from its own frame queue copy and compares it
// depends on scp_pkg
module page_replacer_checker
    import scp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,   // process_id[7:0], page_number[15:8], ref_bit[16]
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    input  logic [OUT_W-1:0] i_m_tdata,   // outcome[1:0], frame_index[4:2], evicted_process[12:5],
                                          // evicted_page[20:13], second_chances[24:21]
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [PID_W-1:0]  pid;
        logic [PAGE_W-1:0] page;
        logic              ref_set;
    } frame_entry_t;

    typedef struct {
        t_outcome          outcome;
        logic [FIDX_W-1:0] frame_index;
        logic [PID_W-1:0]  evicted_process;
        logic [PAGE_W-1:0] evicted_page;
        logic [CHNC_W-1:0] second_chances;
    } lookup_result_t;

    // predicted frame queue, head at frame 0
    frame_entry_t   frames [FRAMES];
    logic           frame_used [FRAMES];
    lookup_result_t expected_lookups [$];

    // drop the head and move every other entry one frame toward it
    task automatic shift_toward_head();
        for (int i = 0; i < FRAMES - 1; i++) begin
            frames[i] = frames[i + 1];
        end
    endtask

    // one page reference: hit, fill the lowest free frame, or rotate and evict
    task automatic replace_page(input logic [PID_W-1:0] pid, input logic [PAGE_W-1:0] page,
                                input logic ref_set, output lookup_result_t res);
        int           slot;
        int           turns;
        frame_entry_t head;
        res.outcome         = OUTC_HIT;
        res.frame_index     = '0;
        res.evicted_process = '0;
        res.evicted_page    = '0;
        res.second_chances  = '0;
        slot = -1;
        // resident lookup ignores the stored reference bit
        for (int i = 0; i < FRAMES; i++) begin
            if (slot < 0 && frame_used[i] && frames[i].pid == pid && frames[i].page == page) begin
                slot = i;
            end
        end
        if (slot >= 0) begin
            res.frame_index = FIDX_W'(slot);
            return;
        end
        // lowest free frame
        for (int i = 0; i < FRAMES; i++) begin
            if (slot < 0 && !frame_used[i]) begin
                slot = i;
            end
        end
        if (slot >= 0) begin
            frame_used[slot]  = 1'b1;
            frames[slot]      = '{pid, page, ref_set};
            res.outcome       = OUTC_FREE;
            res.frame_index   = FIDX_W'(slot);
            return;
        end
        // full queue: give referenced heads a second chance
        turns = 0;
        while (frames[0].ref_set && turns < FRAMES) begin
            head         = frames[0];
            head.ref_set = 1'b0;
            shift_toward_head();
            frames[FRAMES - 1] = head;
            turns++;
        end
        head = frames[0];
        shift_toward_head();
        frames[FRAMES - 1]  = '{pid, page, ref_set};
        res.outcome         = OUTC_EVICT;
        res.frame_index     = FIDX_W'(FRAMES - 1);
        res.evicted_process = head.pid;
        res.evicted_page    = head.page;
        res.second_chances  = CHNC_W'(turns);
    endtask

    // compare one result transaction with the oldest prediction
    always @(posedge i_clk) begin
        lookup_result_t want;
        lookup_result_t got;
        if (!i_rst_n) begin
            for (int i = 0; i < FRAMES; i++) begin
                frame_used[i] = 1'b0;
                frames[i]     = '0;
            end
            expected_lookups.delete();
            o_fail_count = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.outcome         = t_outcome'(i_m_tdata[1:0]);
                got.frame_index     = i_m_tdata[4:2];
                got.evicted_process = i_m_tdata[12:5];
                got.evicted_page    = i_m_tdata[20:13];
                got.second_chances  = i_m_tdata[24:21];
                if (expected_lookups.size() == 0) begin
                    $error("result transaction with no reference pending: data %h", i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = expected_lookups.pop_front();
                    if (got.outcome !== want.outcome) begin
                        $error("outcome mismatch: expected %0d, actual %0d",
                               want.outcome, i_m_tdata[1:0]);
                        o_fail_count++;
                    end
                    if (got.frame_index !== want.frame_index) begin
                        $error("frame_index mismatch: expected %0d, actual %0d",
                               want.frame_index, got.frame_index);
                        o_fail_count++;
                    end
                    if (got.evicted_process !== want.evicted_process) begin
                        $error("evicted_process mismatch: expected %0d, actual %0d",
                               want.evicted_process, got.evicted_process);
                        o_fail_count++;
                    end
                    if (got.evicted_page !== want.evicted_page) begin
                        $error("evicted_page mismatch: expected %0d, actual %0d",
                               want.evicted_page, got.evicted_page);
                        o_fail_count++;
                    end
                    if (got.second_chances !== want.second_chances) begin
                        $error("second_chances mismatch: expected %0d, actual %0d",
                               want.second_chances, got.second_chances);
                        o_fail_count++;
                    end
                end
            end
            // predict each accepted reference transaction
            if (i_s_tvalid && i_s_tready) begin
                replace_page(i_s_tdata[7:0], i_s_tdata[15:8], i_s_tdata[16], want);
                expected_lookups.push_back(want);
            end
        end
        o_pending = expected_lookups.size();
    end

endmodule

// ----- tb/sv/tb.sv -----
// top of the page replacer testbench: clock, reset, reference stimulus,
// result back-pressure, watchdog and verdict
// depends on scp_pkg, second_chance_page_replacer and page_replacer_checker
module tb;
    import scp_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int RANDOM_ITEMS = 1540;
    localparam int POOL_SIZE    = 12;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;    // process_id[7:0], page_number[15:8], ref_bit[16]
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;    // outcome[1:0], frame_index[4:2], evicted_process[12:5],
                                  // evicted_page[20:13], second_chances[24:21]
    int               fail_count;
    int               pending;
    int               idle_cycles;
    bit               no_idle;
    logic [15:0]      key_pool [POOL_SIZE];

    second_chance_page_replacer dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    page_replacer_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock, period 2
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog on cycles without any transaction
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // present one reference after a random gap and hold it until accepted
    task automatic send_reference(input logic [7:0] pid, input logic [7:0] page,
                                  input logic ref_bit);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, ref_bit, page, pid};
        do @(posedge clk); while (!s_tready);
    endtask

    // result side back-pressure, sometimes stalling while a result is waiting
    initial begin
        int stall;
        m_tready = 1'b0;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            @(negedge clk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                if ($urandom_range(0, 1) == 1) begin
                    while (!m_tvalid) @(negedge clk);
                end
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // stimulus and verdict
    initial begin
        int          ref_pct;
        int          slot;
        logic [15:0] key;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        no_idle     = 1'b0;
        ref_pct     = 50;
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = 16'($urandom);
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fill every frame with a referenced page, field extremes among them
        send_reference(8'h00, 8'h00, 1'b1);
        send_reference(8'hff, 8'hff, 1'b1);
        send_reference(8'h00, 8'hff, 1'b1);
        send_reference(8'hff, 8'h00, 1'b1);
        send_reference(8'h55, 8'haa, 1'b1);
        send_reference(8'haa, 8'h55, 1'b1);
        send_reference(8'h01, 8'h02, 1'b1);
        send_reference(8'h03, 8'h04, 1'b1);
        // hit with a different bit leaves the stored bit alone
        send_reference(8'h00, 8'hff, 1'b0);
        // all bits set: full rotation, then the original head goes
        send_reference(8'h09, 8'h09, 1'b1);
        // clear head evicted without rotation
        send_reference(8'h0a, 8'h0a, 1'b0);
        send_reference(8'h09, 8'h09, 1'b0);
        send_reference(8'h0a, 8'h0a, 1'b1);
        send_reference(8'h00, 8'h00, 1'b0);

        // random references: mostly a small working set to get hits and evictions
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if (n % 100 == 0) begin
                case ($urandom_range(0, 3))
                    0: ref_pct = 0;
                    1: ref_pct = 50;
                    2: ref_pct = 90;
                    default: ref_pct = 100;
                endcase
            end
            if ($urandom_range(0, 99) < 60) begin
                slot = $urandom_range(0, POOL_SIZE - 1);
                if ($urandom_range(0, 9) == 0) begin
                    key_pool[slot] = 16'($urandom);
                end
                key = key_pool[slot];
            end else begin
                key = 16'($urandom);
            end
            send_reference(key[7:0], key[15:8], $urandom_range(0, 99) < ref_pct);
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        // drain, then allow for anything still in flight
        while (pending != 0) @(negedge clk);
        repeat (2 * FRAMES + 8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/scp_pkg.sv
hdl/second_chance_page_replacer.sv
hdl/scp_checker.sv
tb/sv/page_replacer_checker.sv
tb/sv/tb.sv
